### sv/hpq_pkg.sv
// shared types and codes for the heap priority queue
package hpq_pkg;

  // command mode of an input word
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_EX_ROOT,
    S_EX_LAST,
    S_EX_LOAD,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_CMP
  } state_t;

endpackage

### sv/hpq_mem.sv
// heap entry storage: one write port, one registered read port
module hpq_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 42
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/min_heap_priority_queue.sv
// binary min-heap priority queue with a shared key comparator and a small sequencer
//
// Each command word (insert or extract-min) is taken when start is high and busy
// is low, and yields exactly one result word: out_valid is high for one cycle with
// out_status, out_key, out_tag and out_entries. The receiver cannot stall, so the
// result must be captured in that cycle. Entries live in a single-port-write,
// registered-read memory; the entry being moved is held in a register (hole
// method), so each sift-up level costs one memory read and one compare on the
// shared comparator, each sift-down level up to two reads and two compares.
// Sequence: a rejected command (insert when full, extract when empty) gives its
// result in the cycle after acceptance. For each level it climbs, an insert
// reads the parent, then compares and writes. An extract reads the root and the
// last entry, loads the last entry as the moving one, then per level it sinks
// reads the left child, reads the right child if any and compares the two, then
// compares and writes. The memory read port, one access per cycle, serializes the steps.
// Insert results carry zero key and tag; out_entries is the count after the word.
module min_heap_priority_queue #(
  parameter int HEAP_DEPTH = 256,
  parameter int KEY_BITS   = 32,
  parameter int TAG_BITS   = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_mode,
  input  logic [KEY_BITS-1:0]                in_key,
  input  logic [TAG_BITS-1:0]                in_tag,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [KEY_BITS-1:0]                out_key,
  output logic [TAG_BITS-1:0]                out_tag,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]    out_entries
);

  localparam int AW = $clog2(HEAP_DEPTH);       // slot index width
  localparam int EW = $clog2(HEAP_DEPTH + 1);   // entry count width
  localparam int IW = AW + 2;                   // child index width, no overflow
  localparam int DW = KEY_BITS + TAG_BITS;      // stored word

  // sequencer state
  hpq_pkg::state_t  state_r, state_nxt;

  // heap bookkeeping
  logic [EW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;         // current hole position

  // entry being moved (new entry on insert, last entry on extract)
  logic [KEY_BITS-1:0]  mov_key_r, mov_key_nxt;
  logic [TAG_BITS-1:0]  mov_tag_r, mov_tag_nxt;

  // chosen child during sift-down
  logic [KEY_BITS-1:0]  pick_key_r, pick_key_nxt;
  logic [TAG_BITS-1:0]  pick_tag_r, pick_tag_nxt;
  logic [AW-1:0]        pick_idx_r, pick_idx_nxt;

  // result registers
  logic                 out_valid_r, out_valid_nxt;
  hpq_pkg::status_t     out_status_r, out_status_nxt;
  logic [KEY_BITS-1:0]  out_key_r, out_key_nxt;
  logic [TAG_BITS-1:0]  out_tag_r, out_tag_nxt;

  // memory port
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [DW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [DW-1:0]        mem_rdata;
  logic [KEY_BITS-1:0]  rd_key;
  logic [TAG_BITS-1:0]  rd_tag;

  // shared comparator
  logic [KEY_BITS-1:0]  cmp_a, cmp_b;
  logic                 cmp_lt;

  // index helpers
  logic [AW-1:0]        parent_idx;
  logic [IW-1:0]        lc_idx, rc_idx, n_ext;
  logic                 accept, is_full, is_empty;

  hpq_mem #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_key = mem_rdata[DW-1:TAG_BITS];
  assign rd_tag = mem_rdata[TAG_BITS-1:0];

  assign busy     = (state_r != hpq_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count_r == EW'(HEAP_DEPTH));
  assign is_empty = (count_r == '0);

  // parent of the hole, only used when pos is nonzero
  assign parent_idx = (pos_r - AW'(1)) >> 1;
  // children of the hole, compared against the count after extract
  assign lc_idx = IW'({pos_r, 1'b1});
  assign rc_idx = lc_idx + IW'(1);
  assign n_ext  = IW'(count_r);

  // operand select for the one comparator
  always_comb begin
    case (state_r)
      hpq_pkg::S_DN_R: begin
        // right child strictly smaller than left: pick right
        cmp_a = rd_key;
        cmp_b = pick_key_r;
      end
      hpq_pkg::S_DN_CMP: begin
        // chosen child strictly smaller than moving entry: swap
        cmp_a = pick_key_r;
        cmp_b = mov_key_r;
      end
      default: begin
        // sift-up: moving entry strictly smaller than parent
        cmp_a = mov_key_r;
        cmp_b = rd_key;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hpq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_mode == hpq_pkg::MODE_EXTRACT) begin
            state_nxt = is_empty ? hpq_pkg::S_IDLE : hpq_pkg::S_EX_ROOT;
          end else begin
            state_nxt = is_full ? hpq_pkg::S_IDLE : hpq_pkg::S_UP;
          end
        end
      end
      hpq_pkg::S_UP:      state_nxt = (pos_r == '0) ? hpq_pkg::S_IDLE : hpq_pkg::S_UP_CMP;
      hpq_pkg::S_UP_CMP:  state_nxt = cmp_lt ? hpq_pkg::S_UP : hpq_pkg::S_IDLE;
      hpq_pkg::S_EX_ROOT: state_nxt = hpq_pkg::S_EX_LAST;
      hpq_pkg::S_EX_LAST: state_nxt = hpq_pkg::S_EX_LOAD;
      hpq_pkg::S_EX_LOAD: state_nxt = hpq_pkg::S_DN;
      hpq_pkg::S_DN:      state_nxt = (lc_idx >= n_ext) ? hpq_pkg::S_IDLE : hpq_pkg::S_DN_L;
      hpq_pkg::S_DN_L:    state_nxt = (rc_idx < n_ext) ? hpq_pkg::S_DN_R : hpq_pkg::S_DN_CMP;
      hpq_pkg::S_DN_R:    state_nxt = hpq_pkg::S_DN_CMP;
      hpq_pkg::S_DN_CMP:  state_nxt = cmp_lt ? hpq_pkg::S_DN : hpq_pkg::S_IDLE;
      default:            state_nxt = hpq_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    mov_key_nxt    = mov_key_r;
    mov_tag_nxt    = mov_tag_r;
    pick_key_nxt   = pick_key_r;
    pick_tag_nxt   = pick_tag_r;
    pick_idx_nxt   = pick_idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_tag_nxt    = out_tag_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = {mov_key_r, mov_tag_r};
    mem_raddr      = '0;

    unique case (state_r)
      hpq_pkg::S_IDLE: begin
        if (accept) begin
          out_key_nxt    = '0;
          out_tag_nxt    = '0;
          out_status_nxt = hpq_pkg::ST_OK;
          if (in_mode == hpq_pkg::MODE_EXTRACT) begin
            if (is_empty) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = hpq_pkg::ST_EMPTY;
            end else begin
              count_nxt = count_r - EW'(1);
            end
          end else begin
            if (is_full) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = hpq_pkg::ST_FULL;
            end else begin
              mov_key_nxt = in_key;
              mov_tag_nxt = in_tag;
              pos_nxt     = count_r[AW-1:0];
              count_nxt   = count_r + EW'(1);
            end
          end
        end
      end
      hpq_pkg::S_UP: begin
        if (pos_r == '0) begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
        end else begin
          mem_raddr = parent_idx;
        end
      end
      hpq_pkg::S_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          // parent moves down into the hole
          mem_wdata = mem_rdata;
          pos_nxt   = parent_idx;
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      hpq_pkg::S_EX_ROOT: begin
        mem_raddr = '0;
      end
      hpq_pkg::S_EX_LAST: begin
        // count already holds the index of the last entry
        mem_raddr   = count_r[AW-1:0];
        out_key_nxt = rd_key;
        out_tag_nxt = rd_tag;
      end
      hpq_pkg::S_EX_LOAD: begin
        mov_key_nxt = rd_key;
        mov_tag_nxt = rd_tag;
        pos_nxt     = '0;
      end
      hpq_pkg::S_DN: begin
        if (lc_idx >= n_ext) begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
        end else begin
          mem_raddr = lc_idx[AW-1:0];
        end
      end
      hpq_pkg::S_DN_L: begin
        pick_key_nxt = rd_key;
        pick_tag_nxt = rd_tag;
        pick_idx_nxt = lc_idx[AW-1:0];
        if (rc_idx < n_ext) begin
          mem_raddr = rc_idx[AW-1:0];
        end
      end
      hpq_pkg::S_DN_R: begin
        // equal keys keep the left child
        if (cmp_lt) begin
          pick_key_nxt = rd_key;
          pick_tag_nxt = rd_tag;
          pick_idx_nxt = rc_idx[AW-1:0];
        end
      end
      hpq_pkg::S_DN_CMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          // smaller child moves up into the hole
          mem_wdata = {pick_key_r, pick_tag_r};
          pos_nxt   = pick_idx_r;
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    mov_key_r    <= mov_key_nxt;
    mov_tag_r    <= mov_tag_nxt;
    pick_key_r   <= pick_key_nxt;
    pick_tag_r   <= pick_tag_nxt;
    pick_idx_r   <= pick_idx_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_tag_r    <= out_tag_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key     = out_key_r;
  assign out_tag     = out_tag_r;
  assign out_entries = count_r;

  // count never runs past capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= EW'(HEAP_DEPTH))
    else $error("entry count above heap depth");

  // a result word only appears once the sequencer is back at rest
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == hpq_pkg::S_IDLE))
    else $error("result word while sequencer busy");

  // extract on empty heap answers at once with the empty status
  a_empty_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == hpq_pkg::MODE_EXTRACT) && is_empty)
      |=> (out_valid_r && (out_status_r == hpq_pkg::ST_EMPTY)))
    else $error("missing empty status on extract");

  // sift-up compare never runs at the root
  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hpq_pkg::S_UP_CMP) |-> (pos_r != '0))
    else $error("sift-up compare at root");

endmodule
